// ===== rtl/core/spi_panel_link_with_rx_fifo_core_macros.svh =====
// Assertion macros shared by the panel link RTL.
`ifndef SPI_PANEL_LINK_WITH_RX_FIFO_CORE_MACROS_SVH
`define SPI_PANEL_LINK_WITH_RX_FIFO_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SPL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SPL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/spl_pkg.sv =====
// Types, register map and reply tables for the panel link core.
package spl_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic capture;
        logic execute;
        logic respond;
    } t_dp_cmd;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [11:0] REG_CTRL0  = 12'h000;
    localparam logic [11:0] REG_CTRL1  = 12'h004;
    localparam logic [11:0] REG_DATA0  = 12'h008;
    localparam logic [11:0] REG_STATUS = 12'h00C;
    localparam logic [11:0] REG_DATA1  = 12'h018;

    localparam logic [31:0] STATUS_TX_NOT_FULL = 32'h0000_0002;

    localparam logic [7:0] CMD_RDID   = 8'h04;
    localparam logic [7:0] CMD_RDID1  = 8'hDA;
    localparam logic [7:0] CMD_RDID2  = 8'hDB;
    localparam logic [7:0] CMD_RDID3  = 8'hDC;
    localparam logic [7:0] CMD_ID_MAX = 8'hDF;

    function automatic logic f_is_id(input logic [7:0] b);
        f_is_id = (b == CMD_RDID) || (b inside {[CMD_RDID1:CMD_ID_MAX]});
    endfunction

    function automatic logic [2:0] f_reply_len(input logic [7:0] cmd);
        case (cmd)
            CMD_RDID:  f_reply_len = 3'd4;
            CMD_RDID1: f_reply_len = 3'd1;
            CMD_RDID2: f_reply_len = 3'd1;
            CMD_RDID3: f_reply_len = 3'd1;
            default:   f_reply_len = 3'd0;
        endcase
    endfunction

    function automatic logic [8:0] f_reply_word(input logic [7:0] cmd, input logic [1:0] idx);
        logic [8:0] w;
        w = 9'h000;
        case (cmd)
            CMD_RDID: begin
                case (idx)
                    2'd0:    w = 9'h000;
                    2'd1:    w = 9'h006;
                    2'd2:    w = 9'h10A;
                    default: w = 9'h128;
                endcase
            end
            CMD_RDID1: w = {8'h06, 1'b0};
            CMD_RDID2: w = {8'h85, 1'b0};
            CMD_RDID3: w = {8'h4A, 1'b0};
            default:   w = 9'h000;
        endcase
        f_reply_word = w;
    endfunction

endpackage

// ===== rtl/core/spi_panel_link_with_rx_fifo_core.sv =====
// Top level of the panel link SPI controller with receive FIFO.
// Usage:
//   A register access is issued by driving i_operation, i_reg_offset and
//   i_write_data with start high while busy is low; that edge accepts it.
//   Exactly one result per access appears on o_read_data with o_strobe high
//   for one cycle; writes return zero. The receiver cannot stall, so the
//   result must be taken in that cycle.
//   Sequence: the accept edge, then an execute cycle, then the strobe cycle.
//   busy stays high across execute and strobe; the next access may be
//   accepted the cycle after the strobe. The three steps are set by the
//   sequencer and the registered read port of the RX FIFO memory.
//   Data port writes send a 9-bit frame and push one received word into the
//   RX FIFO (dropped when full); panel ID commands flush it and load a reply.
//   Data port reads pop the FIFO, returning zero when empty.
//   Reset (synchronous, active low) clears control words, FIFO pointers and
//   reply state; FIFO contents need no clearing pass.
`include "spi_panel_link_with_rx_fifo_core_macros.svh"

module spi_panel_link_with_rx_fifo_core import spl_pkg::*; #(
    parameter int RX_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [11:0] i_reg_offset,
    input  logic [31:0] i_write_data,
    output logic        o_strobe,
    output logic [31:0] o_read_data
);

    t_dp_cmd dp_cmd;

    spl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (dp_cmd)
    );

    spl_dp #(
        .RX_DEPTH (RX_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_operation  (i_operation),
        .i_reg_offset (i_reg_offset),
        .i_write_data (i_write_data),
        .o_read_data  (o_read_data)
    );

    `SPL_ASSERT_NXT(a_accept_to_strobe, i_clk, i_rst_n, start && !busy, ##1 o_strobe, "no strobe two cycles after accept")
    `SPL_ASSERT_IMP(a_strobe_busy, i_clk, i_rst_n, o_strobe, busy, "strobe while idle")
    `SPL_ASSERT_NXT(a_strobe_release, i_clk, i_rst_n, o_strobe, !busy && !o_strobe, "not released after strobe")

endmodule

// ===== rtl/core/spl_ctrl.sv =====
// Transaction sequencer: accept, execute, respond.
module spl_ctrl import spl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output logic    o_strobe,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_EXEC;
            end
            ST_EXEC: n_state = ST_RESP;
            ST_RESP: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        o_cmd.respond = 1'b0;
        busy          = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy          = 1'b0;
                o_cmd.capture = start;
            end
            ST_EXEC: o_cmd.execute = 1'b1;
            ST_RESP: o_cmd.respond = 1'b1;
            default: busy = 1'b1;
        endcase
        o_strobe = o_cmd.respond;
    end

endmodule

// ===== rtl/core/spl_dp.sv =====
// Register file, reply sequencer and receive FIFO of the panel link.
`include "spi_panel_link_with_rx_fifo_core_macros.svh"

module spl_dp import spl_pkg::*; #(
    parameter int RX_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic        i_operation,
    input  logic [11:0] i_reg_offset,
    input  logic [31:0] i_write_data,
    output logic [31:0] o_read_data
);

    localparam int PTR_W  = $clog2(RX_DEPTH);
    localparam int FILL_W = $clog2(RX_DEPTH + 1);
    localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(RX_DEPTH);
    localparam logic [PTR_W:0]    DEPTH_S = (PTR_W+1)'(RX_DEPTH);
    localparam logic [PTR_W-1:0]  LAST_P  = PTR_W'(RX_DEPTH - 1);

    // captured transaction
    logic        r_op;
    logic [11:0] r_off;
    logic [31:0] r_wdata;

    logic [31:0]       r_ctrl0;
    logic [31:0]       r_ctrl1;
    logic [PTR_W-1:0]  r_head;
    logic [FILL_W-1:0] r_fill;
    logic [8:0]        r_reply [4];
    logic [2:0]        r_reply_len;
    logic [2:0]        r_reply_pos;
    logic [8:0]        r_mem [RX_DEPTH];
    logic [8:0]        r_mem_q;
    logic [31:0]       r_result;
    logic              r_use_mem;

    logic             is_data;
    logic             frame_send;
    logic             data_pop;
    logic [8:0]       frame;
    logic             is_cmd;
    logic [7:0]       cmd;
    logic             reply_left;
    logic [8:0]       reply_word;
    logic [PTR_W:0]   tail_sum;
    logic [PTR_W:0]   tail_wrap;
    logic [PTR_W-1:0] tail;
    logic [PTR_W-1:0] head_inc;
    logic             fifo_full;
    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    logic [8:0]       mem_wdata;
    logic [31:0]      reg_value;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_operation;
            r_off   <= i_reg_offset;
            r_wdata <= i_write_data;
        end
    end

    always_comb begin
        is_data    = (r_off == REG_DATA0) || (r_off == REG_DATA1);
        frame_send = i_cmd.execute && (r_op == OP_WRITE) && is_data;
        data_pop   = i_cmd.execute && (r_op == OP_READ) && is_data && (r_fill != '0);
        frame      = r_wdata[8:0];
        // D/C set frames are never ID commands
        is_cmd     = !frame[8] && (f_is_id(frame[7:0]) || f_is_id(frame[8:1]));
        cmd        = f_is_id(frame[7:0]) ? frame[7:0] : frame[8:1];
        reply_left = r_reply_pos < r_reply_len;
        reply_word = reply_left ? r_reply[r_reply_pos[1:0]] : 9'h000;
        tail_sum   = {1'b0, r_head} + (PTR_W+1)'(r_fill);
        tail_wrap  = tail_sum - DEPTH_S;
        tail       = (tail_sum >= DEPTH_S) ? tail_wrap[PTR_W-1:0] : tail_sum[PTR_W-1:0];
        head_inc   = (r_head == LAST_P) ? '0 : r_head + 1'b1;
        fifo_full  = r_fill == DEPTH_F;
        mem_we     = frame_send && (is_cmd || !fifo_full);
        mem_waddr  = is_cmd ? '0 : tail;
        mem_wdata  = is_cmd ? 9'h000 : reply_word;
    end

    always_comb begin
        case (r_off)
            REG_CTRL0:  reg_value = r_ctrl0;
            REG_CTRL1:  reg_value = r_ctrl1;
            REG_STATUS: reg_value = STATUS_TX_NOT_FULL | (32'(r_fill) << 4);
            default:    reg_value = 32'h0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl0     <= '0;
            r_ctrl1     <= '0;
            r_head      <= '0;
            r_fill      <= '0;
            r_reply_len <= '0;
            r_reply_pos <= '0;
            r_use_mem   <= 1'b0;
        end else if (i_cmd.execute) begin
            r_use_mem <= data_pop;
            if (r_op == OP_WRITE) begin
                if (r_off == REG_CTRL0) r_ctrl0 <= r_wdata;
                if (r_off == REG_CTRL1) r_ctrl1 <= r_wdata;
            end
            if (frame_send) begin
                if (is_cmd) begin
                    // ID read: flush FIFO, reload reply, queue a zero word
                    r_head      <= '0;
                    r_fill      <= FILL_W'(1);
                    r_reply_len <= f_reply_len(cmd);
                    r_reply_pos <= '0;
                end else begin
                    if (reply_left) r_reply_pos <= r_reply_pos + 3'd1;
                    if (!fifo_full) r_fill <= r_fill + 1'b1;
                end
            end else if (data_pop) begin
                r_head <= head_inc;
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_send && is_cmd) begin
            for (int i = 0; i < 4; i++) begin
                r_reply[i] <= f_reply_word(cmd, 2'(i));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (data_pop) r_mem_q <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) r_result <= (r_op == OP_READ) ? reg_value : 32'h0;
    end

    assign o_read_data = r_use_mem ? {23'h0, r_mem_q} : r_result;

    `SPL_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= DEPTH_F, "rx fill over depth")
    `SPL_ASSERT_NXT(a_id_flush, i_clk, i_rst_n, frame_send && is_cmd, (r_fill == FILL_W'(1)) && (r_head == '0), "id command did not flush fifo")
    `SPL_ASSERT_IMP(a_write_zero, i_clk, i_rst_n, i_cmd.respond && (r_op == OP_WRITE), o_read_data == 32'h0, "write returned nonzero data")

endmodule

// ===== tb/spi_panel_link_with_rx_fifo_core_tb.sv =====
// Self-checking testbench for the panel link SPI controller with its RX FIFO.
`timescale 1ns / 1ps

module spi_panel_link_with_rx_fifo_core_tb import spl_pkg::*;;

    localparam int CLK_PERIOD     = 12;
    localparam int RX_SLOTS       = 16;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;

    // Tracks register and FIFO state, predicts read data, compares results.
    class rx_link_scoreboard;
        logic [31:0] ctrl_zero;
        logic [31:0] ctrl_one;
        logic [8:0]  rx_mem [RX_SLOTS];
        logic [3:0]  rx_head;
        logic [4:0]  rx_fill;
        logic [8:0]  reply_word [4];
        logic [2:0]  reply_len;
        logic [2:0]  reply_pos;
        logic [31:0] pending_read_data [$];
        int          failures;
        int          results_seen;
        int          id_cmds;
        int          dropped_words;
        int          pops;

        function void clear();
            ctrl_zero     = '0;
            ctrl_one      = '0;
            rx_head       = '0;
            rx_fill       = '0;
            reply_len     = '0;
            reply_pos     = '0;
            failures      = 0;
            results_seen  = 0;
            id_cmds       = 0;
            dropped_words = 0;
            pops          = 0;
            pending_read_data.delete();
        endfunction

        function bit is_id_code(logic [7:0] b);
            return (b == CMD_RDID) || (b >= CMD_RDID1 && b <= CMD_ID_MAX);
        endfunction

        function void push_word(logic [8:0] word);
            if (rx_fill < RX_SLOTS) begin
                rx_mem[rx_head + rx_fill[3:0]] = word;
                rx_fill++;
            end else begin
                dropped_words++;
            end
        endfunction

        function void load_reply(logic [7:0] cmd);
            reply_len = 3'd0;
            reply_pos = 3'd0;
            case (cmd)
                CMD_RDID: begin
                    reply_word[0] = 9'h000;
                    reply_word[1] = 9'h006;
                    reply_word[2] = 9'h10A;
                    reply_word[3] = 9'h128;
                    reply_len = 3'd4;
                end
                CMD_RDID1: begin
                    reply_word[0] = 9'h00C;
                    reply_len = 3'd1;
                end
                CMD_RDID2: begin
                    reply_word[0] = 9'h10A;
                    reply_len = 3'd1;
                end
                CMD_RDID3: begin
                    reply_word[0] = 9'h094;
                    reply_len = 3'd1;
                end
                default: ;
            endcase
        endfunction

        function void send_frame(logic [8:0] frame);
            logic [8:0] word;
            logic [7:0] cmd;
            bit         cmd_hit;
            word    = '0;
            cmd     = '0;
            cmd_hit = 0;
            // D/C set means data: never an ID command
            if (!frame[8]) begin
                if (is_id_code(frame[7:0])) begin
                    cmd_hit = 1;
                    cmd = frame[7:0];
                end else if (is_id_code(frame[8:1])) begin
                    cmd_hit = 1;
                    cmd = frame[8:1];
                end
            end
            if (cmd_hit) begin
                id_cmds++;
                rx_head = '0;
                rx_fill = '0;
                load_reply(cmd);
            end else if (reply_pos < reply_len) begin
                word = reply_word[reply_pos[1:0]];
                reply_pos++;
            end
            push_word(word);
        endfunction

        function logic [31:0] pop_word();
            logic [31:0] w;
            w = '0;
            if (rx_fill != 0) begin
                w = {23'b0, rx_mem[rx_head]};
                rx_head++;
                rx_fill--;
                pops++;
            end
            return w;
        endfunction

        function void note_access(logic op, logic [11:0] off, logic [31:0] data);
            logic [31:0] rd;
            rd = '0;
            if (op == OP_WRITE) begin
                case (off)
                    REG_CTRL0: ctrl_zero = data;
                    REG_CTRL1: ctrl_one = data;
                    REG_DATA0, REG_DATA1: send_frame(data[8:0]);
                    default: ;
                endcase
            end else begin
                case (off)
                    REG_CTRL0: rd = ctrl_zero;
                    REG_CTRL1: rd = ctrl_one;
                    REG_DATA0, REG_DATA1: rd = pop_word();
                    REG_STATUS: rd = STATUS_TX_NOT_FULL | ({26'b0, 1'b0, rx_fill} << 4);
                    default: rd = '0;
                endcase
            end
            pending_read_data.push_back(rd);
        endfunction

        function void check_read(logic [31:0] actual);
            logic [31:0] want;
            results_seen++;
            if (pending_read_data.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("[%0t] unexpected result read_data=0x%08h", $realtime, actual);
                return;
            end
            want = pending_read_data.pop_front();
            if (actual !== want) begin
                failures++;
                if (failures <= 10)
                    $display("[%0t] read_data mismatch: expected 0x%08h, got 0x%08h",
                             $realtime, want, actual);
            end
        endfunction

        function int pending_count();
            return pending_read_data.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_operation;
    logic [11:0] i_reg_offset;
    logic [31:0] i_write_data;
    logic        o_strobe;
    logic [31:0] o_read_data;

    rx_link_scoreboard sb = new;

    int burst_left;
    bit steady_mode;
    int issued;
    int idle_cycles;

    spi_panel_link_with_rx_fifo_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_reg_offset (i_reg_offset),
        .i_write_data (i_write_data),
        .o_strobe     (o_strobe),
        .o_read_data  (o_read_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_read(o_read_data);
    end

    // Ends the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // One register access; returns at the edge that accepts it
    task automatic issue(input logic op, input logic [11:0] off, input logic [31:0] data);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady_mode ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        start        <= 1'b1;
        i_operation  <= op;
        i_reg_offset <= off;
        i_write_data <= data;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_access(op, off, data);
        issued++;
    endtask

    function automatic logic [11:0] data_port();
        return $urandom_range(0, 1) ? REG_DATA0 : REG_DATA1;
    endfunction

    function automatic logic [31:0] with_frame(logic [8:0] frame);
        logic [31:0] v;
        v = $urandom;
        v[8:0] = frame;
        return v;
    endfunction

    function automatic logic [8:0] id_frame();
        logic [7:0] codes [7];
        codes = '{CMD_RDID, CMD_RDID1, CMD_RDID2, CMD_RDID3, 8'hDD, 8'hDE, CMD_ID_MAX};
        // shifted form only reaches the 0x04 command, since D/C must be clear
        if ($urandom_range(0, 3) == 0)
            return {CMD_RDID, 1'($urandom_range(0, 1))};
        return {1'b0, codes[$urandom_range(0, 6)]};
    endfunction

    function automatic logic [11:0] any_offset();
        case ($urandom_range(0, 7))
            0: return REG_CTRL0;
            1: return REG_CTRL1;
            2: return REG_DATA0;
            3: return REG_DATA1;
            4: return REG_STATUS;
            default: return 12'($urandom);
        endcase
    endfunction

    task automatic id_sequence();
        int n;
        issue(OP_WRITE, data_port(), with_frame(id_frame()));
        n = $urandom_range(0, 20);
        repeat (n) begin
            if ($urandom_range(0, 5) == 0)
                issue(OP_READ, REG_STATUS, $urandom);
            else
                issue(OP_WRITE, data_port(), with_frame(9'($urandom)));
        end
        n = $urandom_range(0, 20);
        repeat (n) begin
            if ($urandom_range(0, 5) == 0)
                issue(OP_READ, REG_STATUS, $urandom);
            else
                issue(OP_READ, data_port(), $urandom);
        end
    endtask

    task automatic control_access();
        logic [31:0] v;
        logic [11:0] off;
        case ($urandom_range(0, 3))
            0: v = '0;
            1: v = '1;
            default: v = $urandom;
        endcase
        off = $urandom_range(0, 1) ? REG_CTRL0 : REG_CTRL1;
        issue(OP_WRITE, off, v);
        issue(OP_READ, off, $urandom);
    endtask

    task automatic fill_and_drain();
        repeat ($urandom_range(14, 20))
            issue(OP_WRITE, data_port(), with_frame({1'b1, 8'($urandom)}));
        issue(OP_READ, REG_STATUS, $urandom);
        repeat ($urandom_range(14, 20))
            issue(OP_READ, data_port(), $urandom);
    endtask

    initial begin
        start        = 1'b0;
        i_operation  = OP_READ;
        i_reg_offset = '0;
        i_write_data = '0;
        i_rst_n      = 1'b0;
        idle_cycles  = 0;
        burst_left   = 0;
        steady_mode  = 0;
        issued       = 0;
        sb.clear();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset values, extremes, ID commands, unknown offsets
        issue(OP_READ,  REG_CTRL0,  32'hFFFF_FFFF);
        issue(OP_READ,  REG_CTRL1,  32'h0);
        issue(OP_READ,  REG_STATUS, 32'h0);
        issue(OP_READ,  REG_DATA0,  32'h0);
        issue(OP_WRITE, REG_CTRL0,  32'hFFFF_FFFF);
        issue(OP_WRITE, REG_CTRL1,  32'hA5A5_5A5A);
        issue(OP_READ,  REG_CTRL0,  32'h0);
        issue(OP_READ,  REG_CTRL1,  32'h0);
        issue(OP_WRITE, REG_STATUS, 32'hFFFF_FFFF);
        issue(OP_WRITE, 12'hFFF,    32'hFFFF_FFFF);
        issue(OP_READ,  12'hFFF,    32'h0);
        issue(OP_WRITE, REG_DATA0,  32'hFFFF_FE04);
        repeat (5) issue(OP_WRITE, REG_DATA1, 32'h0000_01FF);
        issue(OP_READ,  REG_STATUS, 32'h0);
        repeat (6) issue(OP_READ, REG_DATA1, 32'h0);
        issue(OP_WRITE, REG_DATA0,  32'h0000_0009);
        issue(OP_WRITE, REG_DATA0,  32'h0000_00DA);
        issue(OP_WRITE, REG_DATA0,  32'h0000_01DA);
        issue(OP_WRITE, REG_DATA1,  32'h0000_00DF);
        issue(OP_WRITE, REG_DATA1,  32'h0000_00DD);
        issue(OP_READ,  REG_DATA0,  32'h0);
        issue(OP_WRITE, REG_CTRL0,  32'h0);

        while (issued < RANDOM_ITEMS) begin
            if ($urandom_range(0, 7) == 0)
                steady_mode = ~steady_mode;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: id_sequence();
                4, 5:       control_access();
                6:          fill_and_drain();
                default:
                    repeat ($urandom_range(1, 6))
                        issue(1'($urandom), any_offset(), $urandom);
            endcase
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.pending_count() != 0) begin
            sb.failures += sb.pending_count();
            $display("%0d expected results never arrived", sb.pending_count());
        end
        $display("Ran %0d register accesses: %0d ID commands, %0d FIFO pops, %0d words dropped",
                 issued, sb.id_cmds, sb.pops, sb.dropped_words);
        $display("Checked %0d results, %0d failures", sb.results_seen, sb.failures);
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
